FILE: design/abst_pkg.sv
package abst_pkg;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_WALK
  } fsm_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_ZERO      = 3'd5
  } status_t;

  // control part of the walk token passed from level to level
  typedef struct packed {
    logic    valid;
    cmd_t    cmd;
    logic    resolved;
    status_t status;
  } walk_ctl_t;

  localparam int COUNT_BITS = 10;

endpackage

FILE: design/abst_cell.sv
module abst_cell #(
  parameter int LEVEL       = 0,
  parameter int TREE_LEVELS = 10,
  parameter int KEY_BITS    = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr_en,
  input  logic [TREE_LEVELS-2:0]     clr_addr,
  input  abst_pkg::walk_ctl_t        in_ctl,
  input  logic [TREE_LEVELS-1:0]     in_idx,
  input  logic [KEY_BITS-1:0]        in_key,
  output abst_pkg::walk_ctl_t        out_ctl,
  output logic [TREE_LEVELS-1:0]     out_idx,
  output logic [KEY_BITS-1:0]        out_key
);

  localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
  localparam int DEPTH = 1 << AW;

  logic [KEY_BITS-1:0]    mem [DEPTH];
  logic [KEY_BITS-1:0]    rdata;
  abst_pkg::walk_ctl_t    ctl;
  logic [TREE_LEVELS-1:0] idx;
  logic [KEY_BITS-1:0]    key;
  logic                   wr_en;
  logic                   slot_empty;
  logic                   slot_hit;
  logic                   go_left;

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_addr[AW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[idx[AW-1:0]] <= key;
    end
    rdata <= mem[in_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= in_ctl;
    end
    idx <= in_idx;
    key <= in_key;
  end

  assign slot_empty = (rdata == '0);
  assign slot_hit   = (rdata == key);
  assign go_left    = ($signed(key) < $signed(rdata));

  always_comb begin
    out_ctl = ctl;
    wr_en   = 1'b0;
    if (ctl.valid && !ctl.resolved) begin
      if (slot_empty) begin
        out_ctl.resolved = 1'b1;
        if (ctl.cmd == abst_pkg::CMD_INSERT) begin
          out_ctl.status = abst_pkg::ST_INSERTED;
          wr_en          = 1'b1;
        end else begin
          out_ctl.status = abst_pkg::ST_NOT_FOUND;
        end
      end else if (slot_hit) begin
        out_ctl.resolved = 1'b1;
        out_ctl.status   = (ctl.cmd == abst_pkg::CMD_INSERT) ?
                           abst_pkg::ST_DUPLICATE : abst_pkg::ST_FOUND;
      end
    end
  end

  // child slot: 2i when smaller, 2i+1 when larger
  assign out_idx = {idx[TREE_LEVELS-2:0], ~go_left};
  assign out_key = key;

endmodule

FILE: design/array_bst_insert_search_core.sv
// Implicit binary search tree, one cell per tree level, each owning the slots
// of its level. An item is taken when start is high and busy is low; its
// result appears as a one-cycle done strobe after the key has passed every
// level's register (a zero key is answered in the next cycle, outside the
// tree), and the key walks down one level per clock. One item is in flight at
// a time; busy stays high until the done strobe and falls in that cycle. After
// reset a counter wipes every slot, while busy is high. Results are not held:
// the receiver must take them in the strobe cycle.
module array_bst_insert_search_core #(
  parameter int TREE_LEVELS = 10,
  parameter int KEY_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [31:0] key,
  output logic        done,
  output logic [2:0]  status,
  output logic [9:0]  node_count,
  output logic        tree_empty,
  output logic [31:0] min_key,
  output logic [31:0] max_key
);

  abst_pkg::fsm_t         state;
  abst_pkg::fsm_t         state_next;
  logic [TREE_LEVELS-2:0] clr_cnt;
  logic                   clr_en;
  logic                   feed;
  logic [KEY_BITS-1:0]    key_in;
  logic                   key_zero;
  logic [abst_pkg::COUNT_BITS-1:0] count;
  logic [KEY_BITS-1:0]    smallest;
  logic [KEY_BITS-1:0]    largest;

  abst_pkg::walk_ctl_t    ctl_chain [TREE_LEVELS+1];
  logic [TREE_LEVELS-1:0] idx_chain [TREE_LEVELS+1];
  logic [KEY_BITS-1:0]    key_chain [TREE_LEVELS+1];

  abst_pkg::walk_ctl_t    tail;
  logic [KEY_BITS-1:0]    tail_key;

  assign key_in   = KEY_BITS'($signed(key));
  assign key_zero = (key_in == '0);

  always_comb begin
    ctl_chain[0].valid    = feed && !key_zero;
    ctl_chain[0].cmd      = abst_pkg::cmd_t'(cmd);
    ctl_chain[0].resolved = 1'b0;
    ctl_chain[0].status   = (cmd == abst_pkg::CMD_INSERT) ?
                            abst_pkg::ST_FULL : abst_pkg::ST_NOT_FOUND;
  end
  assign idx_chain[0] = TREE_LEVELS'(1);
  assign key_chain[0] = key_in;

  for (genvar g = 0; g < TREE_LEVELS; g++) begin : g_level
    abst_cell #(
      .LEVEL      (g),
      .TREE_LEVELS(TREE_LEVELS),
      .KEY_BITS   (KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr_en  (clr_en),
      .clr_addr(clr_cnt),
      .in_ctl  (ctl_chain[g]),
      .in_idx  (idx_chain[g]),
      .in_key  (key_chain[g]),
      .out_ctl (ctl_chain[g+1]),
      .out_idx (idx_chain[g+1]),
      .out_key (key_chain[g+1])
    );
  end

  assign tail     = ctl_chain[TREE_LEVELS];
  assign tail_key = key_chain[TREE_LEVELS];

  always_comb begin
    state_next = state;
    case (state)
      abst_pkg::FSM_CLEAR: begin
        if (clr_cnt == '1) state_next = abst_pkg::FSM_IDLE;
      end
      abst_pkg::FSM_IDLE: begin
        if (start && !key_zero) state_next = abst_pkg::FSM_WALK;
      end
      abst_pkg::FSM_WALK: begin
        if (tail.valid) state_next = abst_pkg::FSM_IDLE;
      end
      default: state_next = abst_pkg::FSM_CLEAR;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    clr_en = 1'b0;
    feed   = 1'b0;
    case (state)
      abst_pkg::FSM_CLEAR: clr_en = 1'b1;
      abst_pkg::FSM_IDLE: begin
        busy = 1'b0;
        feed = start;
      end
      abst_pkg::FSM_WALK: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= abst_pkg::FSM_CLEAR;
      clr_cnt  <= '0;
      count    <= '0;
      smallest <= '0;
      largest  <= '0;
      done     <= 1'b0;
      status   <= abst_pkg::ST_INSERTED;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (clr_en) clr_cnt <= clr_cnt + 1'b1;
      if (feed && key_zero) begin
        done   <= 1'b1;
        status <= abst_pkg::ST_ZERO;
      end
      if (state == abst_pkg::FSM_WALK && tail.valid) begin
        done   <= 1'b1;
        status <= tail.status;
        if (tail.status == abst_pkg::ST_INSERTED) begin
          if (count != '1) count <= count + 1'b1;
          if (count == '0) begin
            smallest <= tail_key;
            largest  <= tail_key;
          end else begin
            if ($signed(tail_key) < $signed(smallest)) smallest <= tail_key;
            if ($signed(tail_key) > $signed(largest)) largest <= tail_key;
          end
        end
      end
    end
  end

  assign node_count = count;
  assign tree_empty = (count == '0);
  assign min_key    = 32'($signed(smallest));
  assign max_key    = 32'($signed(largest));

endmodule
